/* hdl/orbit_view_matrix_top_defines.svh */
// ----------------------------------------------------------------------------
// Orbit view matrix assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ORBIT_VIEW_MATRIX_TOP_DEFINES_SVH
`define ORBIT_VIEW_MATRIX_TOP_DEFINES_SVH

// Assertion that is switched off while rst is high.
`define OVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define OVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ovm_pkg.sv */
// ----------------------------------------------------------------------------
// Orbit view matrix package
// Constants, divisor tables and rounding helpers shared by the block.
// ----------------------------------------------------------------------------
package ovm_pkg;

  // Default parameter values.
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int UNIT_FRAC_BITS_DEF = 14;

  // Pipeline depths: the sine/cosine unit and the whole block.
  localparam int SC_STAGES   = 21;
  localparam int PIPE_STAGES = 26;

  // Fixed-point constants in Q30.
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Distance clamp, Q8.8.
  localparam logic [15:0] DIST_MIN = 16'd256;
  localparam logic [15:0] DIST_MAX = 16'd12800;

  // Horner divisors and their 2^32 reciprocals (rounded down).
  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;
  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [COS_STEPS] =
    '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)};
  localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

  // Quadrant codes of a binary angle.
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET_X = 2'd0;
  localparam logic [1:0] REG_TARGET_Y = 2'd1;
  localparam logic [1:0] REG_TARGET_Z = 2'd2;

  // Arithmetic right shift with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
    logic [63:0] m;
    logic [63:0] res;
    m = v[63] ? 64'(-v) : 64'(v);
    if (s == 0) begin
      return v;
    end
    res = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(res) : $signed(res);
  endfunction

  // Saturate to a 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -64'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  // Saturate to a 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

/* hdl/ovm_req_if.sv */
// ----------------------------------------------------------------------------
// Orbit view request channel
// Valid/ready channel that carries yaw, pitch and eye distance.
// ----------------------------------------------------------------------------
interface ovm_req_if;
  logic               valid;
  logic               ready;
  logic        [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic        [15:0] eye_distance;

  modport source (output valid, output yaw_angle, output pitch_angle,
                  output eye_distance, input ready);
  modport sink (input valid, input yaw_angle, input pitch_angle,
                input eye_distance, output ready);
endinterface

/* hdl/ovm_rsp_if.sv */
// ----------------------------------------------------------------------------
// Orbit view result channel
// Valid/ready channel that carries the three view matrix rows.
// ----------------------------------------------------------------------------
interface ovm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [31:0] right_shift;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [31:0] up_shift;
  logic signed [15:0] back_x;
  logic signed [15:0] back_y;
  logic signed [15:0] back_z;
  logic signed [31:0] back_shift;

  modport source (output valid, output right_x, output right_y, output right_z,
                  output right_shift, output up_x, output up_y, output up_z,
                  output up_shift, output back_x, output back_y, output back_z,
                  output back_shift, input ready);
  modport sink (input valid, input right_x, input right_y, input right_z,
                input right_shift, input up_x, input up_y, input up_z,
                input up_shift, input back_x, input back_y, input back_z,
                input back_shift, output ready);
endinterface

/* hdl/ovm_horner_step.sv */
// ----------------------------------------------------------------------------
// Horner step
// One step t' = 1 - ((r2 * t) >> 30) / DIVISOR over three register stages.
// ----------------------------------------------------------------------------
module ovm_horner_step
  import ovm_pkg::*;
#(
  parameter logic [7:0]  DIVISOR = 8'd2,
  parameter logic [31:0] RECIP   = 32'h8000_0000
) (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [29:0] r2,
  input  logic [30:0] t_in,
  output logic [30:0] t_out
);

  logic [60:0] prod_n;
  logic [29:0] n_a;
  logic [61:0] prod_q;
  logic [29:0] n_b;
  logic [29:0] q_b;
  logic [37:0] qd;
  logic [37:0] rem;
  logic        inc;

  // Stage A: scale the running term by r squared.
  assign prod_n = 61'(r2) * 61'(t_in);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_a <= 30'(prod_n >> 30);
    end
  end

  // Stage B: quotient estimate by reciprocal, at most one below the true value.
  assign prod_q = 62'(n_a) * 62'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n_b <= n_a;
      q_b <= 30'(prod_q >> 32);
    end
  end

  // Stage C: correct the quotient and subtract from one.
  assign qd  = 38'(q_b) * 38'(DIVISOR);
  assign rem = 38'(n_b) - qd;
  assign inc = rem >= 38'(DIVISOR);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_out <= ONE_Q30 - 31'(q_b) - 31'(inc);
    end
  end

endmodule

/* hdl/ovm_sincos.sv */
// ----------------------------------------------------------------------------
// Binary angle sine and cosine
// Pipelined quadrant reduction and Taylor series, Q30 results.
// ----------------------------------------------------------------------------
module ovm_sincos
  import ovm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [SC_STAGES-1:0]  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]    sin_q30,
  output logic signed [31:0]    cos_q30
);

  localparam int CARRY = SC_STAGES - 1;

  logic [31:0] turn;
  logic [29:0] xfrac;
  logic        swap_c;
  logic [29:0] xarg;
  logic [60:0] arg_prod;
  logic [59:0] r_sq;

  logic [29:0] r_s  [CARRY];
  logic [29:0] r2_s [CARRY];
  logic [1:0]  q_s  [CARRY];
  logic        sw_s [CARRY];

  logic [30:0] st_t [SIN_STEPS];
  logic [30:0] ct_t [COS_STEPS];

  logic [60:0] sfin_prod;
  logic [30:0] sfin_a;
  logic [30:0] sfin_b;
  logic [30:0] sfin_c;

  logic [30:0] s_mag;
  logic [30:0] c_mag;
  logic signed [31:0] s0;
  logic signed [31:0] c0;

  // Stage 0: split the turn into a quadrant and a reflected fraction.
  assign turn     = 32'(angle) << (32 - ANGLE_BITS);
  assign xfrac    = turn[29:0];
  assign swap_c   = xfrac > 30'h2000_0000;
  assign xarg     = swap_c ? 30'(ONE_Q30 - 31'(xfrac)) : xfrac;
  assign arg_prod = 61'(xarg) * 61'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_s[0]  <= 30'((arg_prod + 61'd536870912) >> 30);
      r2_s[0] <= '0;
      q_s[0]  <= turn[31:30];
      sw_s[0] <= swap_c;
    end
  end

  // Stage 1: square of the radian argument.
  assign r_sq = 60'(r_s[0]) * 60'(r_s[0]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r_s[1]  <= r_s[0];
      r2_s[1] <= 30'((r_sq + 60'd536870912) >> 30);
      q_s[1]  <= q_s[0];
      sw_s[1] <= sw_s[0];
    end
  end

  // Later stages carry the argument, quadrant and reflection along.
  for (genvar j = 2; j < CARRY; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[j]) begin
        r_s[j]  <= r_s[j-1];
        r2_s[j] <= r2_s[j-1];
        q_s[j]  <= q_s[j-1];
        sw_s[j] <= sw_s[j-1];
      end
    end
  end

  // Sine series lane.
  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
    if (k == 0) begin : g_first
      ovm_horner_step #(.DIVISOR(SIN_DIV[k]), .RECIP(SIN_RECIP[k])) u_step (
        .clk   (clk),
        .en    (en[4+3*k:2+3*k]),
        .r2    (r2_s[1+3*k]),
        .t_in  (ONE_Q30),
        .t_out (st_t[k])
      );
    end else begin : g_next
      ovm_horner_step #(.DIVISOR(SIN_DIV[k]), .RECIP(SIN_RECIP[k])) u_step (
        .clk   (clk),
        .en    (en[4+3*k:2+3*k]),
        .r2    (r2_s[1+3*k]),
        .t_in  (st_t[k-1]),
        .t_out (st_t[k])
      );
    end
  end

  // Cosine series lane.
  for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
    if (k == 0) begin : g_first
      ovm_horner_step #(.DIVISOR(COS_DIV[k]), .RECIP(COS_RECIP[k])) u_step (
        .clk   (clk),
        .en    (en[4+3*k:2+3*k]),
        .r2    (r2_s[1+3*k]),
        .t_in  (ONE_Q30),
        .t_out (ct_t[k])
      );
    end else begin : g_next
      ovm_horner_step #(.DIVISOR(COS_DIV[k]), .RECIP(COS_RECIP[k])) u_step (
        .clk   (clk),
        .en    (en[4+3*k:2+3*k]),
        .r2    (r2_s[1+3*k]),
        .t_in  (ct_t[k-1]),
        .t_out (ct_t[k])
      );
    end
  end

  // Sine is the series times r; then delay it to meet the cosine lane.
  assign sfin_prod = 61'(r_s[3*SIN_STEPS+1]) * 61'(st_t[SIN_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en[3*SIN_STEPS+2]) begin
      sfin_a <= 31'((sfin_prod + 61'd536870912) >> 30);
    end
    if (en[3*SIN_STEPS+3]) begin
      sfin_b <= sfin_a;
    end
    if (en[3*SIN_STEPS+4]) begin
      sfin_c <= sfin_b;
    end
  end

  // Output stage: undo the reflection and apply the quadrant.
  assign s_mag = sw_s[CARRY-1] ? ct_t[COS_STEPS-1] : sfin_c;
  assign c_mag = sw_s[CARRY-1] ? sfin_c : ct_t[COS_STEPS-1];
  assign s0    = $signed({1'b0, s_mag});
  assign c0    = $signed({1'b0, c_mag});

  always_ff @(posedge clk) begin
    if (en[SC_STAGES-1]) begin
      case (q_s[CARRY-1])
        QUAD_I: begin
          sin_q30 <= s0;
          cos_q30 <= c0;
        end
        QUAD_II: begin
          sin_q30 <= c0;
          cos_q30 <= -s0;
        end
        QUAD_III: begin
          sin_q30 <= -s0;
          cos_q30 <= -c0;
        end
        default: begin
          sin_q30 <= -c0;
          cos_q30 <= s0;
        end
      endcase
    end
  end

endmodule

/* hdl/orbit_view_matrix_top.sv */
// ----------------------------------------------------------------------------
// Orbit view matrix: pipelined from request transaction to result. Throughput
// one transaction per cycle while the result side is ready; most of the depth is
// the 21-stage sine/cosine pipeline (six Horner steps of three stages each).
// Synchronous reset clears the stage valid bits and the target registers.
// ----------------------------------------------------------------------------
`include "orbit_view_matrix_top_defines.svh"

module orbit_view_matrix_top
  import ovm_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ovm_req_if.sink     view_req,
  ovm_rsp_if.source   view_rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam logic signed [PW-1:0] PLIM =
    PW'(((64'd1 << ANGLE_BITS) * 64'd49) / 64'd200);
  localparam int unsigned US = 30 - UNIT_FRAC_BITS;
  localparam int L = PIPE_STAGES - 1;

  // Rotation entry slots.
  localparam int U_RX = 0;
  localparam int U_RZ = 1;
  localparam int U_UX = 2;
  localparam int U_UY = 3;
  localparam int U_UZ = 4;
  localparam int U_BX = 5;
  localparam int U_BY = 6;
  localparam int U_BZ = 7;
  localparam int NU   = 8;

  logic signed [30:0] target_x;
  logic signed [30:0] target_y;
  logic signed [30:0] target_z;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] adv;

  logic signed [PW-1:0]   p_ext;
  logic signed [PW-1:0]   p_sat;
  logic [13:0]            d_clamp;
  logic [ANGLE_BITS-1:0]  yaw_ang;
  logic [ANGLE_BITS-1:0]  pitch_ang;
  logic [13:0]            d_line [PIPE_STAGES-2];

  logic signed [31:0] sy;
  logic signed [31:0] cy;
  logic signed [31:0] sp;
  logic signed [31:0] cp;
  logic signed [63:0] p_sysp;
  logic signed [63:0] p_cysp;
  logic signed [63:0] p_cpsy;
  logic signed [63:0] p_cpcy;

  logic signed [31:0] unit_22 [NU];
  logic signed [61:0] t_rx;
  logic signed [61:0] t_rz;
  logic signed [61:0] t_ux;
  logic signed [61:0] t_uy;
  logic signed [61:0] t_uz;
  logic signed [61:0] t_bx;
  logic signed [61:0] t_by;
  logic signed [61:0] t_bz;
  logic signed [15:0] rot_23 [NU];
  logic signed [15:0] rot_24 [NU];
  logic signed [15:0] rot_25 [NU];
  logic signed [63:0] sum_r;
  logic signed [63:0] sum_u;
  logic signed [63:0] sum_b;
  logic signed [31:0] sh_r;
  logic signed [31:0] sh_u;
  logic signed [31:0] sh_b;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      target_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TARGET_X: target_x <= $signed(pwdata[30:0]);
        REG_TARGET_Y: target_y <= $signed(pwdata[30:0]);
        REG_TARGET_Z: target_z <= $signed(pwdata[30:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TARGET_X: prdata = 32'(target_x);
      REG_TARGET_Y: prdata = 32'(target_y);
      REG_TARGET_Z: prdata = 32'(target_z);
      default:      prdata = '0;
    endcase
  end

  // Stage advance: a stage loads when it is empty or its successor moves.
  assign adv[L] = !v[L] || view_rsp.ready;
  for (genvar j = 0; j < L; j++) begin : g_adv
    assign adv[j] = !v[j] || adv[j+1];
  end
  assign view_req.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= view_req.valid;
      end
      for (int j = 1; j < PIPE_STAGES; j++) begin
        if (adv[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  // Stage 0: saturate pitch, clamp distance, form the binary angles.
  assign p_ext = $signed({{(PW-16){view_req.pitch_angle[15]}}, view_req.pitch_angle});
  assign p_sat = (p_ext > PLIM) ? PLIM : ((p_ext < -PLIM) ? -PLIM : p_ext);
  assign d_clamp = (view_req.eye_distance < DIST_MIN) ? 14'(DIST_MIN) :
                   ((view_req.eye_distance > DIST_MAX) ? 14'(DIST_MAX) :
                    14'(view_req.eye_distance));

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      yaw_ang   <= ANGLE_BITS'(view_req.yaw_angle);
      pitch_ang <= p_sat[ANGLE_BITS-1:0];
      d_line[0] <= d_clamp;
    end
  end

  // Distance rides along until the back translation sum.
  for (genvar j = 1; j < PIPE_STAGES - 2; j++) begin : g_dist
    always_ff @(posedge clk) begin
      if (adv[j]) begin
        d_line[j] <= d_line[j-1];
      end
    end
  end

  // Stages 1 to 21: sine and cosine of yaw and pitch.
  ovm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw_sc (
    .clk     (clk),
    .en      (adv[SC_STAGES:1]),
    .angle   (yaw_ang),
    .sin_q30 (sy),
    .cos_q30 (cy)
  );

  ovm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch_sc (
    .clk     (clk),
    .en      (adv[SC_STAGES:1]),
    .angle   (pitch_ang),
    .sin_q30 (sp),
    .cos_q30 (cp)
  );

  // Stage 22: rotation entries in Q30.
  assign p_sysp = 64'(sy) * 64'(sp);
  assign p_cysp = 64'(cy) * 64'(sp);
  assign p_cpsy = 64'(cp) * 64'(sy);
  assign p_cpcy = 64'(cp) * 64'(cy);

  always_ff @(posedge clk) begin
    if (adv[SC_STAGES+1]) begin
      unit_22[U_RX] <= cy;
      unit_22[U_RZ] <= -sy;
      unit_22[U_UX] <= -32'(round_shift(p_sysp, 30));
      unit_22[U_UY] <= cp;
      unit_22[U_UZ] <= -32'(round_shift(p_cysp, 30));
      unit_22[U_BX] <= 32'(round_shift(p_cpsy, 30));
      unit_22[U_BY] <= sp;
      unit_22[U_BZ] <= 32'(round_shift(p_cpcy, 30));
    end
  end

  // Stage 23: translation terms in Q46 and rounded rotation outputs.
  always_ff @(posedge clk) begin
    if (adv[SC_STAGES+2]) begin
      t_rx <= 62'(unit_22[U_RX]) * 62'(target_x);
      t_rz <= 62'(unit_22[U_RZ]) * 62'(target_z);
      t_ux <= 62'(unit_22[U_UX]) * 62'(target_x);
      t_uy <= 62'(unit_22[U_UY]) * 62'(target_y);
      t_uz <= 62'(unit_22[U_UZ]) * 62'(target_z);
      t_bx <= 62'(unit_22[U_BX]) * 62'(target_x);
      t_by <= 62'(unit_22[U_BY]) * 62'(target_y);
      t_bz <= 62'(unit_22[U_BZ]) * 62'(target_z);
      for (int i = 0; i < NU; i++) begin
        rot_23[i] <= sat16(round_shift(64'(unit_22[i]), US));
      end
    end
  end

  // Stage 24: exact translation sums.
  always_ff @(posedge clk) begin
    if (adv[SC_STAGES+3]) begin
      sum_r  <= -(64'(t_rx) + 64'(t_rz));
      sum_u  <= -(64'(t_ux) + 64'(t_uy) + 64'(t_uz));
      sum_b  <= -(64'(t_bx) + 64'(t_by) + 64'(t_bz))
                - $signed(64'(d_line[SC_STAGES+2]) << 38);
      rot_24 <= rot_23;
    end
  end

  // Stage 25: round to Q16.16 and saturate into the output register.
  always_ff @(posedge clk) begin
    if (adv[L]) begin
      sh_r   <= sat32(round_shift(sum_r, 30));
      sh_u   <= sat32(round_shift(sum_u, 30));
      sh_b   <= sat32(round_shift(sum_b, 30));
      rot_25 <= rot_24;
    end
  end

  assign view_rsp.valid       = v[L];
  assign view_rsp.right_x     = rot_25[U_RX];
  assign view_rsp.right_y     = '0;
  assign view_rsp.right_z     = rot_25[U_RZ];
  assign view_rsp.right_shift = sh_r;
  assign view_rsp.up_x        = rot_25[U_UX];
  assign view_rsp.up_y        = rot_25[U_UY];
  assign view_rsp.up_z        = rot_25[U_UZ];
  assign view_rsp.up_shift    = sh_u;
  assign view_rsp.back_x      = rot_25[U_BX];
  assign view_rsp.back_y      = rot_25[U_BY];
  assign view_rsp.back_z      = rot_25[U_BZ];
  assign view_rsp.back_shift  = sh_b;

  // Assertions.
  `OVM_ASSERT_ALWAYS(a_rst_empties, rst |=> !v[L], "result valid after reset")
  `OVM_ASSERT(a_stall_holds, v[L] && !view_rsp.ready |=> v[L], "stalled result lost")
  `OVM_ASSERT(a_empty_ready, !v[L] |-> view_req.ready, "empty pipeline not ready")
  `OVM_ASSERT(a_up_y_sign, view_rsp.valid |-> !view_rsp.up_y[15], "negative up_y")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Orbit view matrix testbench
// Drives view requests in random bursts, writes the target registers over the
// APB port between phases, and checks every result row against a bit-exact
// fixed-point look-at predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import ovm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned Q30_HALF = 64'd1 << 29;
  localparam longint unsigned QUARTER_PI_STEP = 64'd1686629713;
  localparam int PITCH_MAX = 16056;
  localparam int SETTLE_CYCLES = 40;
  localparam int FIELD_COUNT = 12;

  typedef struct {
    logic        [15:0] yaw;
    logic signed [15:0] pitch;
    logic        [15:0] eye_dist;
  } view_request_t;

  typedef struct {
    logic [31:0] fld [FIELD_COUNT];
  } view_rows_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ovm_req_if req_ch ();
  ovm_rsp_if rsp_ch ();

  orbit_view_matrix_top dut (
    .clk      (clk),
    .rst      (rst),
    .view_req (req_ch),
    .view_rsp (rsp_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Target point as the block should hold it, Q16.16 sign-extended.
  longint tgt_x, tgt_y, tgt_z;

  view_request_t pending_views[$];
  view_rows_t    expected_rows[$];
  int            mismatch_count;
  logic          hold_requests;

  string field_names [FIELD_COUNT] = '{"right_x", "right_y", "right_z", "right_shift",
    "up_x", "up_y", "up_z", "up_shift", "back_x", "back_y", "back_z", "back_shift"};

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounded arithmetic shift, ties away from zero.
  function automatic longint round_away(input longint v, input int s);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Taylor sine and cosine of an argument up to pi/4, all in Q30.
  function automatic void taylor_sincos(input longint unsigned r, output longint s,
                                        output longint c);
    longint unsigned sq, acc;
    longint unsigned sin_div [5] = '{110, 72, 42, 20, 6};
    longint unsigned cos_div [6] = '{132, 90, 56, 30, 12, 2};
    sq = (r * r + Q30_HALF) >> 30;
    acc = Q30_ONE;
    for (int i = 0; i < 5; i++) acc = Q30_ONE - ((sq * acc) >> 30) / sin_div[i];
    s = longint'((r * acc + Q30_HALF) >> 30);
    acc = Q30_ONE;
    for (int i = 0; i < 6; i++) acc = Q30_ONE - ((sq * acc) >> 30) / cos_div[i];
    c = longint'(acc);
  endfunction

  // Sine and cosine of a 16-bit binary angle, reflected into the first octant.
  function automatic void angle_sincos(input logic [15:0] a, output longint s,
                                       output longint c);
    logic [31:0] turn;
    longint unsigned frac;
    longint s0, c0;
    turn = {a, 16'h0000};
    frac = turn[29:0];
    if (frac <= Q30_HALF) begin
      taylor_sincos((frac * QUARTER_PI_STEP + Q30_HALF) >> 30, s0, c0);
    end else begin
      taylor_sincos(((Q30_ONE - frac) * QUARTER_PI_STEP + Q30_HALF) >> 30, c0, s0);
    end
    case (turn[31:30])
      QUAD_I: begin
        s = s0; c = c0;
      end
      QUAD_II: begin
        s = c0; c = -s0;
      end
      QUAD_III: begin
        s = -s0; c = -c0;
      end
      default: begin
        s = -c0; c = s0;
      end
    endcase
  endfunction

  function automatic logic [31:0] unit_entry(input longint v);
    return 32'(16'(clip(round_away(v, 16), -32768, 32767)));
  endfunction

  function automatic logic [31:0] shift_entry(input longint q46);
    return 32'(clip(round_away(q46, 30), -64'sd2147483648, 64'sd2147483647));
  endfunction

  // Look-at rows for one view request with the current target point.
  function automatic view_rows_t look_at_rows(input view_request_t v);
    view_rows_t rows;
    longint pitch, eye_dist, sy, cy, sp, cp;
    longint rx, rz, ux, uy, uz, bx, by, bz;
    pitch = clip(longint'(v.pitch), -PITCH_MAX, PITCH_MAX);
    eye_dist = clip(longint'(v.eye_dist), 256, 12800);
    angle_sincos(v.yaw, sy, cy);
    angle_sincos(16'(pitch), sp, cp);
    rx = cy;
    rz = -sy;
    ux = -round_away(sy * sp, 30);
    uy = cp;
    uz = -round_away(cy * sp, 30);
    bx = round_away(cp * sy, 30);
    by = sp;
    bz = round_away(cp * cy, 30);
    rows.fld[0]  = unit_entry(rx);
    rows.fld[1]  = 32'd0;
    rows.fld[2]  = unit_entry(rz);
    rows.fld[3]  = shift_entry(-(rx * tgt_x + rz * tgt_z));
    rows.fld[4]  = unit_entry(ux);
    rows.fld[5]  = unit_entry(uy);
    rows.fld[6]  = unit_entry(uz);
    rows.fld[7]  = shift_entry(-(ux * tgt_x + uy * tgt_y + uz * tgt_z));
    rows.fld[8]  = unit_entry(bx);
    rows.fld[9]  = unit_entry(by);
    rows.fld[10] = unit_entry(bz);
    rows.fld[11] = shift_entry(-(bx * tgt_x + by * tgt_y + bz * tgt_z)
                               - eye_dist * (64'sd1 << 38));
    return rows;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    view_request_t nxt;
    logic take;
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      take = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        nxt.yaw = req_ch.yaw_angle;
        nxt.pitch = req_ch.pitch_angle;
        nxt.eye_dist = req_ch.eye_distance;
        expected_rows.push_back(look_at_rows(nxt));
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_views.size() > 0 && !hold_requests) begin
          take = 1'b1;
        end
        if (take) begin
          nxt = pending_views.pop_front();
          req_ch.yaw_angle <= nxt.yaw;
          req_ch.pitch_angle <= nxt.pitch;
          req_ch.eye_distance <= nxt.eye_dist;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        req_ch.valid <= take;
      end
    end
  end

  // Result sink: stall pattern switches between open, random and long blocks.
  int stall_phase;
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_phase = 0;
      stall_mode = 0;
    end else begin
      stall_phase++;
      if (stall_phase % 97 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: rsp_ch.ready <= (stall_phase % 16) < 5;
      endcase
    end
  end

  // Result monitor: compare each accepted transaction with the oldest prediction.
  always @(posedge clk) begin
    view_rows_t got, want;
    logic bad;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.fld[0]  = 32'(rsp_ch.right_x);
      got.fld[1]  = 32'(rsp_ch.right_y);
      got.fld[2]  = 32'(rsp_ch.right_z);
      got.fld[3]  = rsp_ch.right_shift;
      got.fld[4]  = 32'(rsp_ch.up_x);
      got.fld[5]  = 32'(rsp_ch.up_y);
      got.fld[6]  = 32'(rsp_ch.up_z);
      got.fld[7]  = rsp_ch.up_shift;
      got.fld[8]  = 32'(rsp_ch.back_x);
      got.fld[9]  = 32'(rsp_ch.back_y);
      got.fld[10] = 32'(rsp_ch.back_z);
      got.fld[11] = rsp_ch.back_shift;
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transaction at %0t", $realtime);
      end else begin
        want = expected_rows.pop_front();
        bad = 1'b0;
        for (int i = 0; i < FIELD_COUNT; i++) begin
          if (got.fld[i] !== want.fld[i]) begin
            bad = 1'b1;
            if (mismatch_count < 10)
              $display("Mismatch %s: expected %0d actual %0d at %0t", field_names[i],
                       $signed(want.fld[i]), $signed(got.fld[i]), $realtime);
          end
        end
        if (bad) mismatch_count++;
      end
    end
  end

  // Register write over the APB port; the target copy follows the write edge.
  task automatic write_target(input logic [1:0] idx, input logic [31:0] value);
    longint v;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = longint'($signed(value[30:0]));
    case (idx)
      REG_TARGET_X: tgt_x = v;
      REG_TARGET_Y: tgt_y = v;
      REG_TARGET_Z: tgt_z = v;
      default: ;
    endcase
  endtask

  task automatic set_target(input logic [30:0] x, input logic [30:0] y, input logic [30:0] z);
    write_target(REG_TARGET_X, {1'($urandom_range(0, 1)), x});
    write_target(REG_TARGET_Y, {1'($urandom_range(0, 1)), y});
    write_target(REG_TARGET_Z, {1'($urandom_range(0, 1)), z});
  endtask

  // Wait until every queued request has gone and every result has come back.
  // The check runs on the falling edge, after the driver has settled.
  task automatic wait_drained();
    while (pending_views.size() > 0 || req_ch.valid || expected_rows.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_view(input int yaw, input int pitch, input int eye_dist);
    view_request_t v;
    v.yaw = 16'(yaw);
    v.pitch = 16'(pitch);
    v.eye_dist = 16'(eye_dist);
    pending_views.push_back(v);
  endtask

  // Random views: mostly inside the clamp ranges, some across the full fields.
  task automatic queue_random_views(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        queue_view($urandom_range(0, 65535), $urandom_range(0, 2 * PITCH_MAX) - PITCH_MAX,
                   $urandom_range(256, 12800));
      else
        queue_view($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
    end
  endtask

  // Stimulus sequence: directed views, then random phases at several targets.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.yaw_angle = '0;
    req_ch.pitch_angle = '0;
    req_ch.eye_distance = '0;
    rsp_ch.ready = 1'b0;
    hold_requests = 1'b0;
    mismatch_count = 0;
    tgt_x = 0;
    tgt_y = 0;
    tgt_z = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset target: quadrant edges, octant reflection, pitch and distance clamps.
    queue_view(0, 0, 256);
    queue_view(16384, 0, 12800);
    queue_view(32768, 0, 1000);
    queue_view(49152, 0, 512);
    queue_view(65535, 0, 256);
    queue_view(8192, 100, 300);
    queue_view(8193, -100, 300);
    queue_view(24576, -8192, 700);
    queue_view(0, 16056, 256);
    queue_view(0, -16056, 256);
    queue_view(1234, 16057, 256);
    queue_view(1234, -16057, 256);
    queue_view(40000, 32767, 0);
    queue_view(40000, -32768, 255);
    queue_view(7, 0, 12801);
    queue_view(60000, 5000, 65535);
    queue_view(30000, -5000, 12800);
    queue_view(65535, 16056, 65535);
    queue_view(0, 0, 0);
    wait_drained();

    // Extreme positive target, drives translations into saturation.
    set_target(31'h3fff_ffff, 31'h3fff_ffff, 31'h3fff_ffff);
    queue_random_views(90);
    queue_view(0, 0, 12800);
    queue_view(32768, 16056, 65535);
    queue_random_views(80);
    // Pause the sender mid-phase until the pipeline empties.
    while (pending_views.size() > 80) @(posedge clk);
    hold_requests <= 1'b1;
    @(posedge clk);
    while (req_ch.valid || expected_rows.size() > 0) @(negedge clk);
    hold_requests <= 1'b0;
    wait_drained();

    // Extreme negative target.
    set_target(31'h4000_0000, 31'h4000_0000, 31'h4000_0000);
    queue_random_views(170);
    wait_drained();

    // Mixed random target: x and y within a modest range, z across the full field.
    set_target(31'($urandom_range(0, 32'h00ff_ffff)) - 31'h0080_0000,
               31'($urandom_range(0, 32'h00ff_ffff)) - 31'h0080_0000,
               31'($urandom_range(0, 32'h7fff_ffff)));
    queue_random_views(170);
    wait_drained();

    // Back to the origin target.
    set_target(31'd0, 31'd0, 31'd0);
    queue_random_views(170);
    wait_drained();

    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
